// File: design/sbs_pkg.sv
package sbs_pkg;

  // default sizes, handed down from the top level
  localparam int DEF_WINDOW      = 1024;
  localparam int DEF_CAPACITY    = 256;
  localparam int DEF_HANDLE_BITS = 16;

  // fixed port widths
  localparam int HANDLE_W  = 16;
  localparam int POS_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_PRED = 2'd0,
    CMD_ORF  = 2'd1,
    CMD_EVID = 2'd2,
    CMD_EMIT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_STORED   = 3'd0,
    STAT_RANGE    = 3'd1,
    STAT_STRAND   = 3'd2,
    STAT_IGNORED  = 3'd3,
    STAT_OVERFLOW = 3'd4,
    STAT_EMITTED  = 3'd5,
    STAT_EMPTY    = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START = 3'd0,
    REG_WINDOW_LEN   = 3'd1,
    REG_FWD_ENABLE   = 3'd2,
    REG_RVS_ENABLE   = 3'd3,
    REG_EVID_ENABLE  = 3'd4,
    REG_ORF_ENABLE   = 3'd5,
    REG_GHOST_FLAGS  = 3'd6,
    REG_SEQ_LENGTH   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEAD_RVS  = 3'd1,
    PH_ITEMS     = 3'd2,
    PH_TRAIL_FWD = 3'd3,
    PH_TRAIL_RVS = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DIFF   = 3'd1,
    S_CHECK  = 3'd2,
    S_INSERT = 3'd3,
    S_EMIT   = 3'd4
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] window_start;
    logic [10:0]      window_len;
    logic             fwd_enable;
    logic             rvs_enable;
    logic             evidence_enable;
    logic             orf_enable;
    logic [1:0]       ghost_flags;
    logic [POS_W-1:0] sequence_length;
  } cfg_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } chain_ctl_t;

endpackage

// File: design/sbs_cell.sv
module sbs_cell import sbs_pkg::*; #(
  parameter int KEY_W = $clog2(DEF_WINDOW),
  parameter int HS_W  = DEF_HANDLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  chain_ctl_t       ctl,
  input  logic [KEY_W-1:0] ins_key,
  input  logic [HS_W-1:0]  ins_handle,
  input  logic             ins_dir,
  input  logic             left_valid,
  input  logic             left_mv,
  input  logic [KEY_W-1:0] left_key,
  input  logic [HS_W-1:0]  left_handle,
  input  logic             left_dir,
  input  logic             right_valid,
  input  logic [KEY_W-1:0] right_key,
  input  logic [HS_W-1:0]  right_handle,
  input  logic             right_dir,
  output logic             valid,
  output logic [KEY_W-1:0] key,
  output logic [HS_W-1:0]  handle,
  output logic             dir,
  output logic             mv
);

  logic take_ins;
  logic take_left;

  // entry moves right on insert when empty or strictly later bucket (keeps ties stable)
  assign mv        = !valid || (key > ins_key);
  assign take_ins  = ctl.insert && mv && !left_mv;
  assign take_left = ctl.insert && mv && left_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_ins) begin
      valid <= 1'b1;
    end else if (take_left) begin
      valid <= left_valid;
    end else if (ctl.pop) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ins) begin
      key    <= ins_key;
      handle <= ins_handle;
      dir    <= ins_dir;
    end else if (take_left) begin
      key    <= left_key;
      handle <= left_handle;
      dir    <= left_dir;
    end else if (ctl.pop) begin
      key    <= right_key;
      handle <= right_handle;
      dir    <= right_dir;
    end
  end

endmodule

// File: design/sbs_ctrl.sv
module sbs_ctrl import sbs_pkg::*; #(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [1:0]                              cmd,
  input  logic [POS_W-1:0]                        position,
  input  logic signed [5:0]                       offset,
  input  logic [HANDLE_W-1:0]                     item_handle,
  input  logic                                    strand,
  input  cfg_t                                    cfg,
  input  logic [(HANDLE_BITS < HANDLE_W ? HANDLE_BITS : HANDLE_W)-1:0] head_handle,
  input  logic                                    head_dir,
  output chain_ctl_t                              ctl,
  output logic [$clog2(WINDOW)-1:0]               ins_key,
  output logic [(HANDLE_BITS < HANDLE_W ? HANDLE_BITS : HANDLE_W)-1:0] ins_handle,
  output logic                                    ins_dir,
  output logic                                    busy,
  output logic                                    done,
  output logic [2:0]                              status,
  output logic [HANDLE_W-1:0]                     out_handle,
  output logic                                    out_strand,
  output logic                                    is_marker,
  output logic [POS_W-1:0]                        marker_position,
  output logic                                    last
);

  localparam int KEY_W = $clog2(WINDOW);
  localparam int HS_W  = HANDLE_BITS < HANDLE_W ? HANDLE_BITS : HANDLE_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [33:0] WIN_X = 34'(WINDOW);

  state_t           state, state_next;
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] count, count_next;

  cmd_t             cur_cmd;
  logic [POS_W-1:0] cur_pos;
  logic [5:0]       cur_off;
  logic [32:0]      diff;
  logic [KEY_W-1:0] key_hold;

  logic [33:0]      bsum;
  logic [33:0]      bcl;
  logic [33:0]      len_raw;
  logic [33:0]      len_eff;
  logic             is_ev;
  status_t          load_status;

  logic             fire;
  logic             emit_item;
  status_t          r_status;
  logic [HANDLE_W-1:0] r_handle;
  logic             r_dir;
  logic             r_marker;
  logic [POS_W-1:0] r_pos;
  logic             r_last;
  status_t          res_status;

  assign busy    = (state != S_IDLE);
  assign ins_key = key_hold;
  assign status  = res_status;

  // bucket = position - window_start + offset, checked against the window
  always_comb begin
    bsum    = {diff[32], diff} + {{28{cur_off[5]}}, cur_off};
    bcl     = bsum[33] ? '0 : bsum;
    len_raw = {23'b0, cfg.window_len};
    len_eff = (len_raw > WIN_X) ? WIN_X : len_raw;
    is_ev   = (cur_cmd == CMD_EVID);
    if (phase != PH_IDLE || (cur_cmd == CMD_ORF && !cfg.orf_enable) ||
        (is_ev && !cfg.evidence_enable)) begin
      load_status = STAT_IGNORED;
    end else if (is_ev && (diff[32] || bcl >= len_eff)) begin
      load_status = STAT_RANGE;
    end else if (is_ev && (ins_dir ? !cfg.rvs_enable : !cfg.fwd_enable)) begin
      load_status = STAT_STRAND;
    end else if (!is_ev && (bsum[33] || bsum >= len_eff)) begin
      load_status = STAT_RANGE;
    end else if (count == CNT_W'(CAPACITY)) begin
      load_status = STAT_OVERFLOW;
    end else begin
      load_status = STAT_STORED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      count <= count_next;
      done  <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur_cmd    <= cmd_t'(cmd);
      cur_pos    <= position;
      cur_off    <= offset;
      ins_handle <= item_handle[HS_W-1:0];
      ins_dir    <= strand;
    end
    if (state == S_DIFF) begin
      diff <= {1'b0, cur_pos} - {1'b0, cfg.window_start};
    end
    if (state == S_CHECK) begin
      key_hold <= bcl[KEY_W-1:0];
    end
    if (fire) begin
      res_status      <= r_status;
      out_handle      <= r_handle;
      out_strand      <= r_dir;
      is_marker       <= r_marker;
      marker_position <= r_pos;
      last            <= r_last;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    count_next = count;
    ctl        = '0;
    fire       = 1'b0;
    emit_item  = 1'b0;
    r_status   = STAT_STORED;
    r_handle   = '0;
    r_dir      = 1'b0;
    r_marker   = 1'b0;
    r_pos      = '0;
    r_last     = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (cmd_t'(cmd) == CMD_EMIT) ? S_EMIT : S_DIFF;
        end
      end
      S_DIFF: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (load_status == STAT_STORED) begin
          state_next = S_INSERT;
        end else begin
          fire       = 1'b1;
          r_status   = load_status;
          state_next = S_IDLE;
        end
      end
      S_INSERT: begin
        ctl.insert = 1'b1;
        count_next = count + CNT_W'(1);
        fire       = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        fire       = 1'b1;
        r_status   = STAT_EMITTED;
        state_next = S_IDLE;
        case (phase)
          PH_IDLE: begin
            if (cfg.ghost_flags[0]) begin
              r_marker   = 1'b1;
              phase_next = PH_LEAD_RVS;
            end else if (count != '0) begin
              emit_item = 1'b1;
            end else if (cfg.ghost_flags[1]) begin
              r_marker   = 1'b1;
              r_pos      = cfg.sequence_length;
              phase_next = PH_TRAIL_RVS;
            end else begin
              r_status = STAT_EMPTY;
            end
          end
          PH_LEAD_RVS: begin
            r_marker = 1'b1;
            r_dir    = 1'b1;
            if (count != '0) begin
              phase_next = PH_ITEMS;
            end else if (cfg.ghost_flags[1]) begin
              phase_next = PH_TRAIL_FWD;
            end else begin
              r_last     = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          PH_ITEMS: begin
            emit_item = 1'b1;
          end
          PH_TRAIL_FWD: begin
            if (cfg.ghost_flags[1]) begin
              r_marker   = 1'b1;
              r_pos      = cfg.sequence_length;
              phase_next = PH_TRAIL_RVS;
            end else begin
              r_status   = STAT_EMPTY;
              phase_next = PH_IDLE;
            end
          end
          PH_TRAIL_RVS: begin
            r_marker   = 1'b1;
            r_dir      = 1'b1;
            r_pos      = cfg.sequence_length;
            r_last     = 1'b1;
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
        if (emit_item) begin
          r_handle   = HANDLE_W'(head_handle);
          r_dir      = head_dir;
          ctl.pop    = 1'b1;
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            if (cfg.ghost_flags[1]) begin
              phase_next = PH_TRAIL_FWD;
            end else begin
              r_last     = 1'b1;
              phase_next = PH_IDLE;
            end
          end else begin
            phase_next = PH_ITEMS;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/stable_bucket_sort_by_position_core.sv
// channel   direction  handshake                      payload
// config    in         cfg_write                      cfg_index, cfg_data
// command   in         start while busy is low        cmd, position, offset, item_handle, strand
// result    out        done, one cycle, no back-press status, out_handle, out_strand, is_marker,
//                                                     marker_position, last
//
// a stored load passes capture, window subtract, range check and chain insert before done;
// a rejected load skips the insert and an emit goes from capture to its result; the next item is taken in the
// cycle that done is shown
// the subtract and the signed add with its range compare sit in separate cycles
// synchronous active-high rst empties the cell chain and returns the run to its idle phase
// the receiver cannot stall: every result is marked by done for exactly one cycle
module stable_bucket_sort_by_position_core import sbs_pkg::*; #(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd,
  input  logic [POS_W-1:0]     position,
  input  logic signed [5:0]    offset,
  input  logic [HANDLE_W-1:0]  item_handle,
  input  logic                 strand,
  output logic                 done,
  output logic [2:0]           status,
  output logic [HANDLE_W-1:0]  out_handle,
  output logic                 out_strand,
  output logic                 is_marker,
  output logic [POS_W-1:0]     marker_position,
  output logic                 last
);

  // bucket index width and stored handle width
  localparam int KEY_W = $clog2(WINDOW);
  localparam int HS_W  = HANDLE_BITS < HANDLE_W ? HANDLE_BITS : HANDLE_W;

  cfg_t             cfg;
  chain_ctl_t       ctl;
  logic [KEY_W-1:0] ins_key;
  logic [HS_W-1:0]  ins_handle;
  logic             ins_dir;

  // cell outputs, cell 0 is the head of the sorted run
  logic             cv [CAPACITY];
  logic             cm [CAPACITY];
  logic [KEY_W-1:0] ck [CAPACITY];
  logic [HS_W-1:0]  ch [CAPACITY];
  logic             cd [CAPACITY];

  // configuration registers, written at once with no handshake back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_start    <= '0;
      cfg.window_len      <= 11'd1024;
      cfg.fwd_enable      <= 1'b1;
      cfg.rvs_enable      <= 1'b1;
      cfg.evidence_enable <= 1'b0;
      cfg.orf_enable      <= 1'b0;
      cfg.ghost_flags     <= 2'b00;
      cfg.sequence_length <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_START: cfg.window_start    <= cfg_data;
        REG_WINDOW_LEN:   cfg.window_len      <= cfg_data[10:0];
        REG_FWD_ENABLE:   cfg.fwd_enable      <= cfg_data[0];
        REG_RVS_ENABLE:   cfg.rvs_enable      <= cfg_data[0];
        REG_EVID_ENABLE:  cfg.evidence_enable <= cfg_data[0];
        REG_ORF_ENABLE:   cfg.orf_enable      <= cfg_data[0];
        REG_GHOST_FLAGS:  cfg.ghost_flags     <= cfg_data[1:0];
        REG_SEQ_LENGTH:   cfg.sequence_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: window arithmetic, checks, run phases and the result register
  sbs_ctrl #(
    .WINDOW      (WINDOW),
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .cmd             (cmd),
    .position        (position),
    .offset          (offset),
    .item_handle     (item_handle),
    .strand          (strand),
    .cfg             (cfg),
    .head_handle     (ch[0]),
    .head_dir        (cd[0]),
    .ctl             (ctl),
    .ins_key         (ins_key),
    .ins_handle      (ins_handle),
    .ins_dir         (ins_dir),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .out_handle      (out_handle),
    .out_strand      (out_strand),
    .is_marker       (is_marker),
    .marker_position (marker_position),
    .last            (last)
  );

  // sorted chain of cells: an insert opens a gap after the last entry of an equal or
  // earlier bucket and the tail shifts right; an emit takes the head and shifts left
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             lv, lm, ld, rv, rd;
    logic [KEY_W-1:0] lk, rk;
    logic [HS_W-1:0]  lh, rh;

    if (i == 0) begin : g_first
      assign lv = 1'b0;
      assign lm = 1'b0;
      assign lk = '0;
      assign lh = '0;
      assign ld = 1'b0;
    end else begin : g_left
      assign lv = cv[i-1];
      assign lm = cm[i-1];
      assign lk = ck[i-1];
      assign lh = ch[i-1];
      assign ld = cd[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv = 1'b0;
      assign rk = '0;
      assign rh = '0;
      assign rd = 1'b0;
    end else begin : g_right
      assign rv = cv[i+1];
      assign rk = ck[i+1];
      assign rh = ch[i+1];
      assign rd = cd[i+1];
    end

    sbs_cell #(
      .KEY_W (KEY_W),
      .HS_W  (HS_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .ins_key      (ins_key),
      .ins_handle   (ins_handle),
      .ins_dir      (ins_dir),
      .left_valid   (lv),
      .left_mv      (lm),
      .left_key     (lk),
      .left_handle  (lh),
      .left_dir     (ld),
      .right_valid  (rv),
      .right_key    (rk),
      .right_handle (rh),
      .right_dir    (rd),
      .valid        (cv[i]),
      .key          (ck[i]),
      .handle       (ch[i]),
      .dir          (cd[i]),
      .mv           (cm[i])
    );
  end

endmodule
